// File: rtl/core/nfi_pkg.sv
`timescale 1ns / 1ps

package nfi_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int Q_FRAC = 16;
    localparam int CFG_W = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_STEP = 2'd1;
    localparam logic [1:0] ST_SAT       = 2'd2;

    localparam logic signed [63:0] ONE_Q   = 64'sh0000_0000_0001_0000;
    localparam logic signed [63:0] SAT_LIM = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] Q_MAX32 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN32 = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic              op;
        logic [3:0]        sample_index;
        logic signed [31:0] abscissa;
        logic signed [31:0] ordinate;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interpolated;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic load_sample;
        logic capture_query;
        logic start_p_div;
        logic take_p;
        logic rd_en;
        logic rd_first_lvl;
        logic start_coef_mul;
        logic take_coef_prod;
        logic start_coef_div;
        logic take_coef_quot;
        logic start_term_mul;
        logic take_term;
        logic load_out;
        logic zero_step;
    } t_dp_cmd;

    typedef struct packed {
        logic h_zero;
        logic mul_done;
        logic div_done;
        logic d0_nonzero;
    } t_dp_sts;

    function automatic logic signed [63:0] sat_lim(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > SAT_LIM) begin
            r = SAT_LIM;
        end else if (v < -SAT_LIM) begin
            r = -SAT_LIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic over_lim(input logic signed [63:0] v);
        return (v > SAT_LIM) || (v < -SAT_LIM);
    endfunction

endpackage

// File: rtl/core/nfi_mul.sv
`timescale 1ns / 1ps

module nfi_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res,
    output logic               o_sat
);
    import nfi_pkg::*;

    localparam logic [2:0] PARTS = 3'd4;

    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sel;
    logic         r_pp_vld;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic signed [63:0] r_res;
    logic         r_sat;

    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shift;
    logic         fin;
    logic         hi_nz, mag_sat;
    logic [63:0]  mag, mag_cl;

    assign a_half   = r_cnt[0] ? r_ua[63:32] : r_ua[31:0];
    assign b_half   = r_cnt[1] ? r_ub[63:32] : r_ub[31:0];
    assign pp_shift = 128'(r_pp) << {r_pp_sel[0] & r_pp_sel[1], r_pp_sel[0] ^ r_pp_sel[1], 5'b0};
    assign fin      = r_busy && (r_cnt == PARTS) && !r_pp_vld;

    // The Q48.16 product keeps bits 79..16; a set bit above them or a magnitude past SAT_LIM saturates.
    assign hi_nz   = |r_acc[127:80];
    assign mag     = r_acc[79:16];
    assign mag_sat = hi_nz || (mag > 64'(SAT_LIM));
    assign mag_cl  = mag_sat ? 64'(SAT_LIM) : mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt != PARTS) begin
                    r_cnt    <= r_cnt + 3'd1;
                    r_pp_vld <= 1'b1;
                end else begin
                    r_pp_vld <= 1'b0;
                end
                if (fin) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt != PARTS) begin
                r_pp     <= a_half * b_half;
                r_pp_sel <= r_cnt[1:0];
            end
            if (r_pp_vld) begin
                r_acc <= r_acc + pp_shift;
            end
            if (fin) begin
                r_res <= r_neg ? -$signed(mag_cl) : $signed(mag_cl);
                r_sat <= mag_sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_sat  = r_sat;

endmodule

// File: rtl/core/nfi_div.sv
`timescale 1ns / 1ps

module nfi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quot
);
    import nfi_pkg::*;

    localparam logic [6:0] STEPS = 7'd64;

    logic [63:0] r_rem, r_quot, r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] trial;
    logic        ge;

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign trial = {r_rem, r_quot[63]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_den  <= i_den[63] ? 64'(-i_den) : 64'(i_den);
            r_neg  <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            r_rem  <= ge ? 64'(trial - {1'b0, r_den}) : trial[63:0];
            r_quot <= {r_quot[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quot) : $signed(r_quot);

endmodule

// File: rtl/core/nfi_datapath.sv
`timescale 1ns / 1ps

module nfi_datapath #(
    parameter int  MAX_POINTS = nfi_pkg::MAX_POINTS_DEF,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nfi_pkg::t_in_item   i_in_item,
    input  nfi_pkg::t_dp_cmd    i_cmd,
    input  logic [IDX_W-1:0]    i_rd_addr,
    input  logic [CNT_W-1:0]    i_k,
    output nfi_pkg::t_dp_sts    o_sts,
    output nfi_pkg::t_out_item  o_out_item
);
    import nfi_pkg::*;

    logic signed [31:0] r_smp [MAX_POINTS];
    logic signed [63:0] r_dif [MAX_POINTS];
    logic signed [31:0] r_x0, r_x1, r_xq;
    logic signed [31:0] r_smp_rd;
    logic signed [63:0] r_dif_rd;
    logic               r_rd_vld, r_rd_first;
    logic [IDX_W-1:0]   r_rd_idx;
    logic signed [63:0] r_p, r_c, r_c_tmp, r_acc, r_prev, r_d0;
    logic               r_flag, r_coef_sat;
    t_out_item          r_out_item;

    logic               smp_wr;
    logic [IDX_W-1:0]   smp_addr, wr_idx;
    logic signed [63:0] rd_data, diff_raw, diff_val;
    logic signed [63:0] mul_a, mul_b, mul_res, div_num, div_den, div_q, sum_raw;
    logic               mul_start, mul_done, mul_sat, div_start, div_done;
    t_out_item          out_next;

    assign smp_wr   = i_cmd.load_sample && (32'(i_in_item.sample_index) < MAX_POINTS);
    assign smp_addr = IDX_W'(i_in_item.sample_index);
    assign wr_idx   = r_rd_idx - 1'b1;
    assign rd_data  = r_rd_first ? 64'(r_smp_rd) : r_dif_rd;
    assign diff_raw = rd_data - r_prev;
    assign diff_val = sat_lim(diff_raw);

    assign mul_start = i_cmd.start_coef_mul | i_cmd.start_term_mul;
    assign mul_a     = r_c;
    assign mul_b     = i_cmd.start_term_mul ? r_d0
                     : r_p - $signed(64'(i_k - 1'b1) << Q_FRAC);
    assign div_start = i_cmd.start_p_div | i_cmd.start_coef_div;
    assign div_num   = i_cmd.start_p_div ? ((64'(r_xq) - 64'(r_x0)) <<< Q_FRAC) : r_c_tmp;
    assign div_den   = i_cmd.start_p_div ? (64'(r_x1) - 64'(r_x0)) : $signed(64'(i_k));
    assign sum_raw   = r_acc + mul_res;

    nfi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res),
        .o_sat   (mul_sat)
    );

    nfi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Sample and difference memories.
    always_ff @(posedge i_clk) begin
        if (smp_wr) begin
            r_smp[smp_addr] <= i_in_item.ordinate;
        end
        if (r_rd_vld && r_rd_idx != '0) begin
            r_dif[wr_idx] <= diff_val;
        end
        r_smp_rd <= r_smp[i_rd_addr];
        r_dif_rd <= r_dif[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= i_rd_addr;
        r_rd_first <= i_cmd.rd_first_lvl;
        if (i_cmd.load_sample && i_in_item.sample_index == 4'd0) begin
            r_x0 <= i_in_item.abscissa;
        end
        if (i_cmd.load_sample && i_in_item.sample_index == 4'd1) begin
            r_x1 <= i_in_item.abscissa;
        end
        if (i_cmd.capture_query) begin
            r_xq       <= i_in_item.abscissa;
            r_c        <= ONE_Q;
            r_flag     <= 1'b0;
            r_coef_sat <= 1'b0;
        end
        if (i_cmd.take_p) begin
            r_p <= div_q;
        end
        // Each returned entry either seeds the level or yields one new difference.
        if (r_rd_vld) begin
            r_prev <= rd_data;
            if (r_rd_idx == '0) begin
                if (r_rd_first) begin
                    r_acc <= rd_data;
                end
            end else begin
                if (over_lim(diff_raw)) begin
                    r_flag <= 1'b1;
                end
                if (r_rd_idx == IDX_W'(1)) begin
                    r_d0 <= diff_val;
                end
            end
        end
        if (i_cmd.take_coef_prod) begin
            r_c_tmp <= mul_res;
            if (mul_sat) begin
                r_coef_sat <= 1'b1;
            end
        end
        if (i_cmd.take_coef_quot) begin
            r_c <= div_q;
        end
        if (i_cmd.start_term_mul && r_coef_sat) begin
            r_flag <= 1'b1;
        end
        if (i_cmd.take_term) begin
            r_acc <= sat_lim(sum_raw);
            if (mul_sat || over_lim(sum_raw)) begin
                r_flag <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_item <= out_next;
        end
    end

    always_comb begin
        if (i_cmd.zero_step) begin
            out_next.interpolated = '0;
            out_next.status       = ST_ZERO_STEP;
        end else if (r_acc > Q_MAX32) begin
            out_next.interpolated = Q_MAX32[31:0];
            out_next.status       = ST_SAT;
        end else if (r_acc < Q_MIN32) begin
            out_next.interpolated = Q_MIN32[31:0];
            out_next.status       = ST_SAT;
        end else begin
            out_next.interpolated = r_acc[31:0];
            out_next.status       = r_flag ? ST_SAT : ST_OK;
        end
    end

    assign o_sts.h_zero     = (r_x1 == r_x0);
    assign o_sts.mul_done   = mul_done;
    assign o_sts.div_done   = div_done;
    assign o_sts.d0_nonzero = (r_d0 != '0);
    assign o_out_item       = r_out_item;

endmodule

// File: rtl/core/nfi_ctrl.sv
`timescale 1ns / 1ps

module nfi_ctrl #(
    parameter int  MAX_POINTS = nfi_pkg::MAX_POINTS_DEF,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_in_op,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [nfi_pkg::CFG_W-1:0] i_cfg_data,
    input  nfi_pkg::t_dp_sts         i_sts,
    output nfi_pkg::t_dp_cmd         o_cmd,
    output logic [IDX_W-1:0]         o_rd_addr,
    output logic [CNT_W-1:0]         o_k
);
    import nfi_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSTART = 4'd1;
    localparam logic [3:0] S_PWAIT  = 4'd2;
    localparam logic [3:0] S_DIFF   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_CMUL   = 4'd5;
    localparam logic [3:0] S_CMULW  = 4'd6;
    localparam logic [3:0] S_CDIV   = 4'd7;
    localparam logic [3:0] S_CDIVW  = 4'd8;
    localparam logic [3:0] S_TERM   = 4'd9;
    localparam logic [3:0] S_TERMW  = 4'd10;
    localparam logic [3:0] S_NEXT   = 4'd11;
    localparam logic [3:0] S_FINISH = 4'd12;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_n, r_k;
    logic [IDX_W-1:0] r_j;
    logic             r_zero;
    logic             r_out_valid;

    logic             in_acc, out_free, last_rd;
    logic [CNT_W-1:0] cfg_n;
    t_dp_cmd          cmd;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign last_rd  = (CNT_W'(r_j) == r_n - r_k);

    always_comb begin
        if (32'(i_cfg_data) < 32'd2) begin
            cfg_n = CNT_W'(2);
        end else if (32'(i_cfg_data) > MAX_POINTS) begin
            cfg_n = CNT_W'(MAX_POINTS);
        end else begin
            cfg_n = CNT_W'(i_cfg_data);
        end
    end

    always_comb begin
        cmd               = '0;
        cmd.load_sample   = in_acc && (i_in_op == OP_LOAD);
        cmd.capture_query = in_acc && (i_in_op == OP_EVAL);
        n_state           = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd.capture_query) n_state = S_PSTART;
            end
            S_PSTART: begin
                cmd.start_p_div = !i_sts.h_zero;
                n_state = i_sts.h_zero ? S_FINISH : S_PWAIT;
            end
            S_PWAIT: begin
                cmd.take_p = i_sts.div_done;
                if (i_sts.div_done) n_state = S_DIFF;
            end
            S_DIFF: begin
                cmd.rd_en        = 1'b1;
                cmd.rd_first_lvl = (r_k == CNT_W'(1));
                if (last_rd) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_CMUL;
            S_CMUL: begin
                cmd.start_coef_mul = 1'b1;
                n_state = S_CMULW;
            end
            S_CMULW: begin
                cmd.take_coef_prod = i_sts.mul_done;
                if (i_sts.mul_done) n_state = S_CDIV;
            end
            S_CDIV: begin
                cmd.start_coef_div = 1'b1;
                n_state = S_CDIVW;
            end
            S_CDIVW: begin
                cmd.take_coef_quot = i_sts.div_done;
                if (i_sts.div_done) n_state = S_TERM;
            end
            S_TERM: begin
                cmd.start_term_mul = i_sts.d0_nonzero;
                n_state = i_sts.d0_nonzero ? S_TERMW : S_NEXT;
            end
            S_TERMW: begin
                cmd.take_term = i_sts.mul_done;
                if (i_sts.mul_done) n_state = S_NEXT;
            end
            S_NEXT: n_state = (r_k == r_n - CNT_W'(1)) ? S_FINISH : S_DIFF;
            S_FINISH: begin
                cmd.load_out  = out_free;
                cmd.zero_step = r_zero;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= CNT_W'(2);
            r_k         <= '0;
            r_j         <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_n <= cfg_n;
            end
            if (r_state == S_PSTART) begin
                r_zero <= i_sts.h_zero;
            end
            if (r_state == S_PWAIT) begin
                r_k <= CNT_W'(1);
                r_j <= '0;
            end
            if (r_state == S_DIFF && !last_rd) begin
                r_j <= r_j + 1'b1;
            end
            if (r_state == S_NEXT) begin
                r_k <= r_k + 1'b1;
                r_j <= '0;
            end
            if (cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_cmd       = cmd;
    assign o_rd_addr   = r_j;
    assign o_k         = r_k;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an item not yet taken");

    a_last_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF && last_rd) |=> (r_state == S_DRAIN))
        else $error("difference sweep did not end after its last entry");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMUL) |-> (r_k >= CNT_W'(1) && r_k < r_n))
        else $error("level counter out of range");

    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n >= CNT_W'(2)) && (32'(r_n) <= MAX_POINTS))
        else $error("point count out of range");

endmodule

// File: rtl/core/newton_forward_interpolator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                                   Item
// input     in         i_in_valid / o_in_ready / i_in_item       load or evaluate
// output    out        o_out_valid / i_out_ready / o_out_item    result and status
// config    in         i_cfg_valid / o_cfg_ready / i_cfg_data    point count
//
// An evaluate item's time is set mostly by the shared 64-step divider, which
// runs once for the position and once per difference level; a zero step
// skips the divider and goes straight to the result.
// Reset is synchronous and active low; the sample memories are not cleared.
// The input channel stalls while an evaluate is in progress, and a finished
// result waits in the output register while the next item is taken.

module newton_forward_interpolator_unit #(
    parameter int MAX_POINTS = nfi_pkg::MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  nfi_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output nfi_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [nfi_pkg::CFG_W-1:0] i_cfg_data
);
    import nfi_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] k;

    nfi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_op     (i_in_item.op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_k         (k)
    );

    nfi_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .i_rd_addr  (rd_addr),
        .i_k        (k),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule
